FILE: hw/rtl/dabb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dabb_pkg
// Shared types and constants for the dual actuator bang-bang position hold.
// ----------------------------------------------------------------------------
package dabb_pkg;

  localparam int unsigned FULL_TURN = 23040;
  localparam int unsigned HALF_TURN = 11520;
  // multiple of a full turn that lifts any scaled target above zero
  localparam int unsigned TGT_BIAS  = 23040 * 365;
  // floor(2^16 / 45), short by less than one after the shift
  localparam int unsigned RECIP_45  = 1456;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_SPEED  = 2'd1,
    KIND_TARGET = 2'd2,
    KIND_STOP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_SPEED_DEADBAND = 3'd0,
    REG_POSITION_DUTY  = 3'd1,
    REG_DRIVE_REVERSE  = 3'd2,
    REG_HOLD_WINDOW    = 3'd3,
    REG_RESUME_WINDOW  = 3'd4,
    REG_STALE_LIMIT_MS = 3'd5,
    REG_TARGET_SCALE   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] command_value;
    logic               side_a_present;
    logic        [15:0] side_a_age_ms;
    logic        [14:0] side_a_angle;
    logic               side_b_present;
    logic        [15:0] side_b_age_ms;
    logic        [14:0] side_b_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] drive_a;
    logic signed [15:0] drive_b;
    logic               in_position_mode;
    logic               held_a;
    logic               held_b;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               settled;
  } side_res_t;

endpackage

FILE: hw/rtl/dual_actuator_bang_bang_position_hold_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_actuator_bang_bang_position_hold_top
// Two-sided bang-bang position hold with velocity mode and hysteresis.
// ----------------------------------------------------------------------------
// an accepted item is held in a_r and evaluated into out_data_r; 1 transaction per
//   cycle unless out_stall holds the result or a tick waits; a tick waits until the
//   scaled target pipeline (multiply, round, mod 23040, three registers) has settled
//   after a target command or a target_scale write; commands are never held for it
// synchronous active-low reset clears mode, stored values, flags and drives;
//   the target pipeline is not reset, and ticks wait while it refills after reset
module dual_actuator_bang_bang_position_hold_top
  import dabb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic [14:0] deadband_r;
  logic [14:0] duty_r;
  logic        reverse_r;
  logic [13:0] hold_win_r;
  logic [13:0] resume_win_r;
  logic [15:0] stale_lim_r;
  logic [15:0] scale_r;

  // block state
  logic               mode_r, mode_nxt;
  logic               prev_mode_r, prev_mode_nxt;
  logic signed [15:0] speed_r, speed_nxt;
  logic signed [15:0] target_r, target_nxt;
  logic signed [15:0] prev_target_r, prev_target_nxt;
  logic [1:0]         settled_r, settled_nxt;
  logic signed [15:0] last_a_r, last_a_nxt;
  logic signed [15:0] last_b_r, last_b_nxt;

  // pipeline
  logic      a_valid_r;
  in_item_t  a_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      a_adv;
  logic      in_fire;
  logic      cfg_fire;

  // scaled target pipeline
  logic signed [32:0] prod_r;
  logic [24:0]        tgtu_r;
  logic [14:0]        wrap_r, wrap_nxt;
  logic [1:0]         wait_r, wait_nxt;
  logic signed [33:0] rnd;
  logic signed [25:0] tgt_s;
  logic [25:0]        tgt_u;
  logic [15:0]        qu;
  logic [26:0]        d_full;
  logic [10:0]        d;
  logic [16:0]        d45;
  logic [16:0]        rem;
  logic [5:0]         rem45;

  // tick evaluation
  logic      fresh_a, fresh_b, have;
  side_res_t res_a, res_b;
  logic      sa, sb;

  function automatic side_res_t side_eval(
    input logic [14:0] wrap,
    input logic        have_rd,
    input logic [14:0] angle,
    input logic        settled,
    input logic [13:0] hold_win,
    input logic [13:0] resume_win,
    input logic [14:0] duty,
    input logic        reverse
  );
    side_res_t          res;
    logic signed [17:0] v;
    logic [15:0]        r;
    logic signed [16:0] err;
    logic [14:0]        mag;
    logic signed [15:0] pos, neg;
    v = $signed({3'b000, wrap}) + 18'sd11520 - $signed({3'b000, angle});
    if (v < 0) begin
      v = v + 18'sd23040;
    end else if (v >= 18'sd23040) begin
      v = v - 18'sd23040;
    end
    r = v[15:0];
    if (r == 16'd0) begin
      r = 16'(FULL_TURN);
    end
    err = $signed({1'b0, r}) - 17'sd11520;
    mag = (err < 0) ? 15'(-err) : 15'(err);
    pos = $signed({1'b0, duty});
    neg = -pos;
    res.drive   = '0;
    res.settled = settled;
    if (!have_rd) begin
      res.settled = 1'b0;
    end else if (settled && (mag <= {1'b0, resume_win})) begin
      res.settled = 1'b1;
    end else if (mag <= {1'b0, hold_win}) begin
      res.settled = 1'b1;
    end else begin
      res.settled = 1'b0;
      res.drive   = ((err > 0) ^ reverse) ? pos : neg;
    end
    return res;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign a_adv    = a_valid_r && (!out_valid_r || !out_stall) &&
                    ((a_r.kind != KIND_TICK) || (wait_r == 2'd0));
  assign in_stall = a_valid_r && !a_adv;
  assign in_fire  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r   <= '0;
      duty_r       <= '0;
      reverse_r    <= 1'b0;
      hold_win_r   <= 14'd64;
      resume_win_r <= 14'd128;
      stale_lim_r  <= 16'd100;
      scale_r      <= 16'd256;
    end else if (cfg_fire) begin
      case (reg_idx_t'(cfg_index))
        REG_SPEED_DEADBAND: deadband_r   <= cfg_data[14:0];
        REG_POSITION_DUTY:  duty_r       <= cfg_data[14:0];
        REG_DRIVE_REVERSE:  reverse_r    <= cfg_data[0];
        REG_HOLD_WINDOW:    hold_win_r   <= cfg_data[13:0];
        REG_RESUME_WINDOW:  resume_win_r <= cfg_data[13:0];
        REG_STALE_LIMIT_MS: stale_lim_r  <= cfg_data;
        REG_TARGET_SCALE:   scale_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // scaled target: round(target * scale / 256) mod 23040
  always_comb begin
    rnd      = 34'(prod_r) + 34'sd128;
    tgt_s    = 26'(rnd >>> 8);
    tgt_u    = 26'(tgt_s) + 26'(TGT_BIAS);
    qu       = tgtu_r[24:9];
    d_full   = 27'(qu) * 27'(RECIP_45);
    d        = d_full[26:16];
    d45      = 17'(d) * 17'd45;
    rem      = 17'(qu) - d45;
    rem45    = (rem[6:0] >= 7'd45) ? 6'(rem[6:0] - 7'd45) : rem[5:0];
    wrap_nxt = {rem45, tgtu_r[8:0]};
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(target_r) * $signed({1'b0, scale_r});
    tgtu_r <= tgt_u[24:0];
    wrap_r <= wrap_nxt;
  end

  always_comb begin
    wait_nxt = (wait_r != 2'd0) ? wait_r - 2'd1 : 2'd0;
    if ((a_adv && (a_r.kind == KIND_TARGET)) ||
        (cfg_fire && (reg_idx_t'(cfg_index) == REG_TARGET_SCALE))) begin
      wait_nxt = 2'd3;
    end
  end

  // item evaluation
  always_comb begin
    fresh_a = a_r.side_a_present && (a_r.side_a_age_ms <= stale_lim_r);
    fresh_b = a_r.side_b_present && (a_r.side_b_age_ms <= stale_lim_r);
    have    = fresh_a || fresh_b;

    mode_nxt        = mode_r;
    prev_mode_nxt   = prev_mode_r;
    speed_nxt       = speed_r;
    target_nxt      = target_r;
    prev_target_nxt = prev_target_r;
    settled_nxt     = settled_r;
    last_a_nxt      = last_a_r;
    last_b_nxt      = last_b_r;

    sa = settled_r[0];
    sb = settled_r[1];
    if (!prev_mode_r || (target_r != prev_target_r)) begin
      sa = 1'b0;
      sb = 1'b0;
    end
    res_a = side_eval(wrap_r, have, fresh_a ? a_r.side_a_angle : a_r.side_b_angle, sa,
                      hold_win_r, resume_win_r, duty_r, reverse_r);
    res_b = side_eval(wrap_r, have, fresh_b ? a_r.side_b_angle : a_r.side_a_angle, sb,
                      hold_win_r, resume_win_r, duty_r, reverse_r);

    case (a_r.kind)
      KIND_SPEED: begin
        speed_nxt = a_r.command_value;
        if (($signed({a_r.command_value[15], a_r.command_value}) >
             $signed({2'b00, deadband_r})) ||
            ($signed({a_r.command_value[15], a_r.command_value}) <
             -$signed({2'b00, deadband_r}))) begin
          mode_nxt = 1'b0;
        end
      end
      KIND_TARGET: begin
        target_nxt = a_r.command_value;
        mode_nxt   = 1'b1;
      end
      KIND_STOP: begin
        speed_nxt = '0;
        mode_nxt  = 1'b0;
      end
      KIND_TICK: begin
        if (mode_r) begin
          prev_target_nxt = target_r;
          settled_nxt     = {res_b.settled, res_a.settled};
          last_a_nxt      = res_a.drive;
          last_b_nxt      = res_b.drive;
        end else begin
          last_a_nxt = speed_r;
          last_b_nxt = speed_r;
        end
        prev_mode_nxt = mode_r;
      end
      default: ;
    endcase
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      wait_r        <= 2'd3;
      mode_r        <= 1'b0;
      prev_mode_r   <= 1'b0;
      speed_r       <= '0;
      target_r      <= '0;
      prev_target_r <= '0;
      settled_r     <= '0;
      last_a_r      <= '0;
      last_b_r      <= '0;
    end else begin
      wait_r <= wait_nxt;
      if (in_fire) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
      if (a_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (a_adv) begin
        mode_r        <= mode_nxt;
        prev_mode_r   <= prev_mode_nxt;
        speed_r       <= speed_nxt;
        target_r      <= target_nxt;
        prev_target_r <= prev_target_nxt;
        settled_r     <= settled_nxt;
        last_a_r      <= last_a_nxt;
        last_b_r      <= last_b_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_r <= in_data;
    end
    if (a_adv) begin
      out_data_r.drive_a          <= last_a_nxt;
      out_data_r.drive_b          <= last_b_nxt;
      out_data_r.in_position_mode <= mode_nxt;
      out_data_r.held_a           <= settled_nxt[0];
      out_data_r.held_b           <= settled_nxt[1];
    end
  end

  // checks
  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    a_adv |=> out_valid_r)
    else $error("evaluated transaction produced no result");

  a_tick_waits_target: assert property (@(posedge clk) disable iff (!rst_n)
    (wait_r != 2'd0) |-> !(a_adv && (a_r.kind == KIND_TICK)))
    else $error("tick evaluated against an unsettled scaled target");

  a_no_reading_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && (a_r.kind == KIND_TICK) && mode_r && !have) |=>
      ((out_data_r.drive_a == 16'sd0) && (out_data_r.drive_b == 16'sd0) &&
       !out_data_r.held_a && !out_data_r.held_b))
    else $error("position tick without readings did not idle both sides");

endmodule

FILE: tb/sv/dual_actuator_bang_bang_position_hold_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_actuator_bang_bang_position_hold_top_tb
// Self-checking bench for the two-sided bang-bang position hold. A directed
// table covers the velocity and speed extremes, deadband edges, target wrap,
// stale and missing encoders and the hold/resume hysteresis. It is followed by
// random command and tick traffic under several register settings, the
// extremes among them. Each result is checked against a cycle-free model of
// the joint controller or a typed row. Inputs idle, results stall at random.
// ----------------------------------------------------------------------------
module dual_actuator_bang_bang_position_hold_top_tb;
  import dabb_pkg::*;

  localparam longint TURN_UNITS = 23040;
  localparam longint HALF_UNITS = 11520;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  // joint state as the block should hold it
  logic               pos_mode, pos_mode_prev;
  logic signed [15:0] speed_hold, target_hold, target_prev;
  logic               held_a_q, held_b_q;
  logic signed [15:0] last_a, last_b;

  // register shadow
  logic [14:0] deadband_q, duty_q;
  logic        reverse_q;
  logic [13:0] hold_q, resume_q;
  logic [15:0] stale_q, scale_q;

  out_item_t pending_reports[$];
  plan_row_t plan[$];

  bit gaps_on, stalls_on;
  int n_sent, n_results, n_mismatch, n_settings, n_pos_ticks, n_held_ticks;

  dual_actuator_bang_bang_position_hold_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint scaled_target();
    return (longint'(target_hold) * longint'(scale_q) + 128) >>> 8;
  endfunction

  function automatic longint angle_error(input longint to, input longint from);
    longint r;
    r = (to - from + HALF_UNITS) % TURN_UNITS;
    if (r < 0) r += TURN_UNITS;
    if (r == 0) r = TURN_UNITS;
    return r - HALF_UNITS;
  endfunction

  function automatic side_res_t side_duty(input longint tgt, input bit have,
                                          input longint ang, input logic held);
    side_res_t r;
    longint err, mag;
    logic signed [15:0] duty;
    r.drive = '0;
    r.settled = held;
    if (!have) begin
      r.settled = 1'b0;
      return r;
    end
    err = angle_error(tgt, ang);
    mag = (err < 0) ? -err : err;
    if (held && mag <= longint'(resume_q)) return r;
    if (mag <= longint'(hold_q)) begin
      r.settled = 1'b1;
      return r;
    end
    r.settled = 1'b0;
    duty = signed'({1'b0, duty_q});
    if (reverse_q) duty = -duty;
    r.drive = (err > 0) ? duty : -duty;
    return r;
  endfunction

  function automatic out_item_t step_joint(input in_item_t it);
    out_item_t r;
    side_res_t sa, sb;
    logic signed [15:0] da, db;
    bit fa, fb;
    longint tgt, ang_a, ang_b;
    case (it.kind)
      KIND_SPEED: begin
        speed_hold = it.command_value;
        if (int'(it.command_value) > int'(deadband_q) ||
            int'(it.command_value) < -int'(deadband_q)) pos_mode = 1'b0;
      end
      KIND_TARGET: begin
        target_hold = it.command_value;
        pos_mode = 1'b1;
      end
      KIND_STOP: begin
        speed_hold = '0;
        pos_mode = 1'b0;
      end
      default: begin
        da = speed_hold;
        db = speed_hold;
        if (pos_mode) begin
          fa = it.side_a_present && (it.side_a_age_ms <= stale_q);
          fb = it.side_b_present && (it.side_b_age_ms <= stale_q);
          ang_a = longint'(it.side_a_angle);
          ang_b = longint'(it.side_b_angle);
          if (!pos_mode_prev || target_hold != target_prev) begin
            held_a_q = 1'b0;
            held_b_q = 1'b0;
            target_prev = target_hold;
          end
          tgt = scaled_target();
          sa = side_duty(tgt, fa || fb, fa ? ang_a : ang_b, held_a_q);
          sb = side_duty(tgt, fa || fb, fb ? ang_b : ang_a, held_b_q);
          da = sa.drive;
          db = sb.drive;
          held_a_q = sa.settled;
          held_b_q = sb.settled;
          n_pos_ticks++;
          if (sa.settled || sb.settled) n_held_ticks++;
        end
        pos_mode_prev = pos_mode;
        last_a = da;
        last_b = db;
      end
    endcase
    r.drive_a = last_a;
    r.drive_b = last_b;
    r.in_position_mode = pos_mode;
    r.held_a = held_a_q;
    r.held_b = held_b_q;
    return r;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] v);
    case (idx)
      REG_SPEED_DEADBAND: deadband_q = v[14:0];
      REG_POSITION_DUTY:  duty_q = v[14:0];
      REG_DRIVE_REVERSE:  reverse_q = v[0];
      REG_HOLD_WINDOW:    hold_q = v[13:0];
      REG_RESUME_WINDOW:  resume_q = v[13:0];
      REG_STALE_LIMIT_MS: stale_q = v;
      REG_TARGET_SCALE:   scale_q = v;
      default: ;
    endcase
  endfunction

  function automatic in_item_t row(input kind_t k, input logic [15:0] cv,
                                   input logic ap, input logic [15:0] aage,
                                   input logic [14:0] aang, input logic bp,
                                   input logic [15:0] bage, input logic [14:0] bang);
    in_item_t it;
    it.kind = k;
    it.command_value = cv;
    it.side_a_present = ap;
    it.side_a_age_ms = aage;
    it.side_a_angle = aang;
    it.side_b_present = bp;
    it.side_b_age_ms = bage;
    it.side_b_angle = bang;
    return it;
  endfunction

  function automatic out_item_t mk_out(input logic [15:0] a, input logic [15:0] b,
                                       input logic m, input logic ha, input logic hb);
    out_item_t r;
    r.drive_a = a;
    r.drive_b = b;
    r.in_position_mode = m;
    r.held_a = ha;
    r.held_b = hb;
    return r;
  endfunction

  function automatic logic [15:0] pick_age();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 16'($urandom_range(0, stale_q));
    if (sel < 8) return stale_q + 16'(sel - 6);
    return 16'($urandom);
  endfunction

  function automatic logic [14:0] pick_angle(input longint aim);
    int unsigned sel;
    longint span, a;
    sel = $urandom_range(0, 9);
    span = longint'(hold_q) + longint'(resume_q) + 24;
    if (sel < 7) begin
      a = (aim + longint'($urandom_range(0, 2 * span)) - span) % TURN_UNITS;
      if (a < 0) a += TURN_UNITS;
      return 15'(a);
    end
    if (sel == 7)
      return $urandom_range(0, 1) ? 15'($urandom_range(0, 40))
                                  : 15'(23039 - $urandom_range(0, 40));
    return 15'($urandom);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned sel;
    int sp;
    longint aim;
    it = '0;
    it.command_value = 16'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 62) begin
      it.kind = KIND_TICK;
    end else if (sel < 78) begin
      it.kind = KIND_TARGET;
      sel = $urandom_range(0, 9);
      if (sel < 2) it.command_value = target_hold;
      else if (sel < 7) it.command_value = 16'(int'($urandom_range(0, 800)) - 400);
    end else if (sel < 92) begin
      it.kind = KIND_SPEED;
      if ($urandom_range(0, 9) < 4) begin
        sp = int'(deadband_q) + int'($urandom_range(0, 2)) - 1;
        it.command_value = 16'($urandom_range(0, 1) ? sp : -sp);
      end
    end else begin
      it.kind = KIND_STOP;
    end
    aim = scaled_target() % TURN_UNITS;
    if (aim < 0) aim += TURN_UNITS;
    it.side_a_present = ($urandom_range(0, 99) < 85);
    it.side_b_present = ($urandom_range(0, 99) < 85);
    it.side_a_age_ms = pick_age();
    it.side_b_age_ms = pick_age();
    it.side_a_angle = pick_angle(aim);
    it.side_b_angle = pick_angle(aim);
    return it;
  endfunction

  task automatic report_mismatch(input string field, input longint got,
                                 input longint want);
    n_mismatch++;
    if (n_mismatch <= MAX_PRINTED)
      $display("%0t: %s mismatch on result %0d: got %0d, expected %0d",
               $realtime, field, n_results, got, want);
  endtask

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    out_item_t pred;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pred = step_joint(it);
    pending_reports.push_back(typed ? want : pred);
    n_sent++;
  endtask

  task automatic load_settings(input logic [15:0] db, input logic [15:0] duty,
                               input logic [15:0] rev, input logic [15:0] hold,
                               input logic [15:0] resume, input logic [15:0] stale,
                               input logic [15:0] scale);
    logic [2:0] idx;
    logic [15:0] val;
    for (int i = 0; i < 8; i++) begin
      idx = 3'(i);
      case (idx)
        REG_SPEED_DEADBAND: val = db;
        REG_POSITION_DUTY:  val = duty;
        REG_DRIVE_REVERSE:  val = rev;
        REG_HOLD_WINDOW:    val = hold;
        REG_RESUME_WINDOW:  val = resume;
        REG_STALE_LIMIT_MS: val = stale;
        REG_TARGET_SCALE:   val = scale;
        default:            val = 16'($urandom);
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      do @(posedge clk); while (!cfg_ready);
      apply_reg(idx, val);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // result side back-pressure
  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = stalls_on ? $urandom_range(0, 3) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected transaction, drive_a", out_data.drive_a, 0);
      end else begin
        want = pending_reports.pop_front();
        if (out_data.drive_a !== want.drive_a)
          report_mismatch("drive_a", out_data.drive_a, want.drive_a);
        if (out_data.drive_b !== want.drive_b)
          report_mismatch("drive_b", out_data.drive_b, want.drive_b);
        if (out_data.in_position_mode !== want.in_position_mode)
          report_mismatch("in_position_mode", out_data.in_position_mode,
                          want.in_position_mode);
        if (out_data.held_a !== want.held_a)
          report_mismatch("held_a", out_data.held_a, want.held_a);
        if (out_data.held_b !== want.held_b)
          report_mismatch("held_b", out_data.held_b, want.held_b);
      end
      n_results++;
    end
  end

  initial begin
    #3_000_000;
    $display("timeout: block stopped responding");
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    pos_mode = 1'b0;
    pos_mode_prev = 1'b0;
    speed_hold = '0;
    target_hold = '0;
    target_prev = '0;
    held_a_q = 1'b0;
    held_b_q = 1'b0;
    last_a = '0;
    last_b = '0;
    deadband_q = '0;
    duty_q = '0;
    reverse_q = 1'b0;
    hold_q = 14'd64;
    resume_q = 14'd128;
    stale_q = 16'd100;
    scale_q = 16'd256;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_settings(16'd100, 16'd1000, 16'd0, 16'd64, 16'd128, 16'd100, 16'd256);

    // velocity extremes and deadband
    plan.push_back('{row(KIND_TICK, 16'd0, 0, 0, 0, 0, 0, 0), 1'b1,
                     mk_out(16'd0, 16'd0, 0, 0, 0)});
    plan.push_back('{row(KIND_SPEED, 16'h7FFF, 0, 0, 0, 0, 0, 0), 1'b1,
                     mk_out(16'd0, 16'd0, 0, 0, 0)});
    plan.push_back('{row(KIND_TICK, 16'd0, 0, 0, 0, 0, 0, 0), 1'b1,
                     mk_out(16'h7FFF, 16'h7FFF, 0, 0, 0)});
    plan.push_back('{row(KIND_SPEED, 16'h8000, 0, 0, 0, 0, 0, 0), 1'b1,
                     mk_out(16'h7FFF, 16'h7FFF, 0, 0, 0)});
    plan.push_back('{row(KIND_TICK, 16'hFFFF, 1, 16'hFFFF, 15'h7FFF, 1, 16'hFFFF, 15'h7FFF),
                     1'b1, mk_out(16'h8000, 16'h8000, 0, 0, 0)});
    plan.push_back('{row(KIND_SPEED, 16'd50, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{row(KIND_TICK, 16'd0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    // position mode, hysteresis, stale and missing encoders
    plan.push_back('{row(KIND_TARGET, 16'd0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{row(KIND_TICK, 16'd0, 1, 0, 0, 1, 0, 0), 1'b1,
                     mk_out(16'd0, 16'd0, 1, 1, 1)});
    plan.push_back('{row(KIND_TICK, 16'd0, 1, 5, 100, 1, 5, 22940), 1'b0, '0});
    plan.push_back('{row(KIND_TICK, 16'd0, 1, 0, 23039, 0, 0, 0), 1'b0, '0});
    plan.push_back('{row(KIND_TICK, 16'd0, 1, 100, 5000, 1, 101, 0), 1'b0, '0});
    plan.push_back('{row(KIND_TICK, 16'd0, 0, 0, 0, 0, 0, 0), 1'b1,
                     mk_out(16'd0, 16'd0, 1, 0, 0)});
    plan.push_back('{row(KIND_TICK, 16'd0, 1, 16'hFFFF, 0, 0, 0, 0), 1'b1,
                     mk_out(16'd0, 16'd0, 1, 0, 0)});
    // half-turn error and out of range angles
    plan.push_back('{row(KIND_TARGET, 16'd11520, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{row(KIND_TICK, 16'd0, 1, 0, 0, 1, 0, 0), 1'b0, '0});
    plan.push_back('{row(KIND_TICK, 16'd0, 1, 0, 15'h7FFF, 1, 16'hFFFF, 0), 1'b0, '0});
    plan.push_back('{row(KIND_TARGET, 16'h8000, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{row(KIND_TICK, 16'd0, 1, 0, 12345, 1, 0, 17000), 1'b0, '0});
    plan.push_back('{row(KIND_TARGET, 16'h7FFF, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{row(KIND_TICK, 16'd0, 1, 0, 0, 1, 0, 23039), 1'b0, '0});
    // speed at the deadband keeps position mode, one past leaves it
    plan.push_back('{row(KIND_TARGET, 16'd5, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{row(KIND_SPEED, 16'd100, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{row(KIND_TICK, 16'd0, 1, 0, 5, 1, 0, 70), 1'b0, '0});
    plan.push_back('{row(KIND_SPEED, -16'sd101, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{row(KIND_STOP, 16'hFFFF, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    plan.push_back('{row(KIND_TICK, 16'd0, 1, 0, 0, 1, 0, 0), 1'b0, '0});
    foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].want);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        1: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 16'hFFFF);
        2: load_settings(16'($urandom_range(0, 500)), 16'd32767, 16'd1, 16'd11520,
                         16'd11520, 16'd100, 16'd256);
        default: load_settings($urandom_range(0, 3) == 0 ? 16'($urandom)
                                                         : 16'($urandom_range(0, 2000)),
                               16'($urandom), 16'($urandom_range(0, 1)),
                               16'($urandom_range(0, 400)), 16'($urandom_range(0, 800)),
                               16'($urandom_range(0, 1000)),
                               $urandom_range(0, 1) ? 16'd256 : 16'($urandom));
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, '0);
      drain();
    end

    $display("%0d transactions sent, %0d results seen, %0d register settings",
             n_sent, n_results, n_settings);
    $display("%0d position-mode ticks, %0d of them with a side held, %0d mismatches",
             n_pos_ticks, n_held_ticks, n_mismatch);
    if (n_mismatch == 0 && pending_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
